// File: rtl/phac_pkg.sv
// ----------------------------------------------------------------------------
// phac_pkg
// Shared types, constants and the CORDIC angle table for the path block.
// ----------------------------------------------------------------------------
package phac_pkg;

  localparam int AngleBits   = 16;
  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps + 1);
  localparam logic [34:0] TwoPiMilliQ16 = 35'd411774832;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] arc;
    logic [15:0] hdg;
    logic [31:0] kap;
    logic        fin;
  } word_t;

  typedef struct packed {
    logic load;      // latch input
    logic geo_start;
    logic div_start;
    logic commit;    // update history (after results, if any)
  } cmd_t;

  typedef struct packed {
    logic geo_done;
    logic div_done;
  } sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051D; 5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4; 5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55; 5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2E; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2F9;
      5'd15: t = 32'h0000517C; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517; 5'd20: t = 32'h0000028B;
      5'd21: t = 32'h00000145; 5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000002; 5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/path_heading_arc_curvature.sv
// ----------------------------------------------------------------------------
// path_heading_arc_curvature
// Streaming arc length, heading and curvature along a polyline.
// ----------------------------------------------------------------------------
// channel | dir | handshake     | payload
// in      | in  | valid / ready | pos_x pos_y end_of_path
// out     | out | valid / ready | out_x out_y arc_length heading curvature final_point
// An inner point passes through geometry (33-step root, the CORDIC loop runs
// beside it), the 51-step divide, the result words and a history update
// before the next point is accepted. Zero ds or heading change skips the
// divide loop. The first point of a path skips both; the second skips the divide.
// A one-word output register lets the next word wait while the sink stalls.
// Synchronous reset clears the path history; no clearing pass.
// ----------------------------------------------------------------------------
module path_heading_arc_curvature
  import phac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic        end_of_path,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] arc_length,
  output logic [15:0] heading,
  output logic [31:0] curvature,
  output logic        final_point
);

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] sel;
  logic [1:0] seen;
  logic       res_load;
  logic       res_free;
  word_t      res;
  word_t      oreg;

  assign res_free = !out_valid || out_ready;

  phac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .end_of_path(end_of_path),
    .in_ready(in_ready), .sts(sts), .cmd(cmd), .sel(sel), .seen(seen),
    .res_load(res_load), .res_free(res_free)
  );

  phac_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sel(sel), .seen(seen),
    .pos_x(pos_x), .pos_y(pos_y), .sts(sts), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1; oreg <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_x       = oreg.x;
  assign out_y       = oreg.y;
  assign arc_length  = oreg.arc;
  assign heading     = oreg.hdg;
  assign curvature   = oreg.kap;
  assign final_point = oreg.fin;

endmodule

// File: rtl/phac_geo.sv
// ----------------------------------------------------------------------------
// phac_geo
// Segment length (bit-serial rounded root) and heading (CORDIC vectoring).
// ----------------------------------------------------------------------------
module phac_geo
  import phac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  output logic               done,
  output logic [32:0]        len,
  output logic [15:0]        hdg
);

  localparam int Shift = 32 - AngleBits;

  logic              busy;
  logic [5:0]        cnt;
  logic [64:0]       sq;
  logic [32:0]       ax;
  logic [32:0]       ay;
  logic [64:0]       mul;
  logic [1:0]        phase;
  logic [65:0]       rad;
  logic [35:0]       rem;
  logic [32:0]       root;
  logic signed [35:0] cx;
  logic signed [35:0] cy;
  logic [31:0]       acc;
  logic              zero;
  logic [StepW-1:0]  ci;
  logic              cbusy;
  logic [35:0]       trial;
  logic [35:0]       rem_sh;
  logic [31:0]       acc_r;
  logic [AngleBits-1:0] a_bits;

  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);
  assign mul = (phase == 2'd0) ? 65'(ax) * 65'(ax) : 65'(ay) * 65'(ay);
  assign rem_sh = {rem[33:0], rad[65:64]};
  assign trial  = {1'b0, root, 2'b01};
  assign acc_r  = acc + 32'(1 << (Shift - 1));
  assign a_bits = acc_r[31:Shift];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; cbusy <= 1'b0; done <= 1'b0; phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cbusy <= 1'b1; phase <= 2'd0; sq <= '0; cnt <= '0;
        rem <= '0; root <= '0; ci <= '0; zero <= (dx == 0) && (dy == 0);
        if (dx[32]) begin
          cx <= 36'(-dx); cy <= 36'(-dy); acc <= 32'h80000000;
        end else begin
          cx <= 36'(dx); cy <= 36'(dy); acc <= '0;
        end
      end else begin
        if (cbusy) begin
          if (32'(ci) == CordicSteps || 32'(ci) >= 32) begin
            cbusy <= 1'b0;
          end else if (cy > 0) begin
            cx <= cx + (cy >>> ci); cy <= cy - (cx >>> ci);
            acc <= acc + atan_turn(5'(ci)); ci <= ci + 1'b1;
          end else begin
            cx <= cx - (cy >>> ci); cy <= cy + (cx >>> ci);
            acc <= acc - atan_turn(5'(ci)); ci <= ci + 1'b1;
          end
        end
        if (busy) begin
          if (phase == 2'd0) begin
            sq <= mul; phase <= 2'd1;
          end else if (phase == 2'd1) begin
            rad <= {1'b0, sq + mul}; phase <= 2'd2; cnt <= '0;
          end else if (phase == 2'd2) begin
            if (rem_sh >= trial) begin
              rem <= rem_sh - trial; root <= {root[31:0], 1'b1};
            end else begin
              rem <= rem_sh; root <= {root[31:0], 1'b0};
            end
            rad <= {rad[63:0], 2'b00};
            if (cnt == 6'd32) phase <= 2'd3; else cnt <= cnt + 1'b1;
          end else if (!cbusy) begin
            busy <= 1'b0; done <= 1'b1;
            len  <= (rem > 36'(root)) ? root + 1'b1 : root;
            if (zero) hdg <= '0;
            else if (AngleBits >= 16) hdg <= 16'(a_bits >> (AngleBits - 16));
            else hdg <= 16'({a_bits, 16'h0} >> AngleBits);
          end
        end
      end
    end
  end

endmodule

// File: rtl/phac_div.sv
// ----------------------------------------------------------------------------
// phac_div
// Curvature: wrapped heading change times 2*pi*1000 over ds, rounded, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module phac_div
  import phac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dth,
  input  logic [31:0] ds,
  output logic        done,
  output logic [31:0] kap
);

  logic        busy;
  logic        neg;
  logic        spec;
  logic [5:0]  cnt;
  logic [50:0] num;
  logic [48:0] den;
  logic [49:0] r;
  logic [49:0] r_sh;
  logic [50:0] q;
  logic [15:0] mag;
  logic [50:0] qr;

  assign mag  = dth[15] ? 16'(-dth) : dth;
  assign r_sh = {r[48:0], num[50]};
  assign qr   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= dth[15];
        spec <= (dth == 0) || (ds == 0);
        if (dth == 0) kap <= '0;
        else kap <= dth[15] ? 32'h80000000 : 32'h7FFFFFFF;
        // add den/2 for rounding, den = ds<<16 so den/2 = ds<<15
        num <= 51'(mag) * 51'(TwoPiMilliQ16) + {4'b0, ds, 15'b0};
        den <= {1'b0, ds, 16'b0};
        r <= '0; q <= '0; cnt <= '0; busy <= 1'b1;
      end else if (busy) begin
        if (spec) begin
          busy <= 1'b0; done <= 1'b1;
        end else if (cnt == 6'd51) begin
          busy <= 1'b0; done <= 1'b1;
          if (!neg) kap <= (qr > 51'h7FFFFFFF) ? 32'h7FFFFFFF : qr[31:0];
          else kap <= (qr > 51'h80000000) ? 32'h80000000 : 32'(-qr[31:0]);
        end else begin
          if (r_sh >= 50'(den)) begin
            r <= r_sh - 50'(den); q <= {q[49:0], 1'b1};
          end else begin
            r <= r_sh; q <= {q[49:0], 1'b0};
          end
          num <= {num[49:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/phac_dp.sv
// ----------------------------------------------------------------------------
// phac_dp
// Datapath: history registers, geometry and divide units, result assembly.
// ----------------------------------------------------------------------------
module phac_dp
  import phac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [1:0]  sel,   // result selector from controller
  input  logic [1:0]  seen,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  output sts_t        sts,
  output word_t       res
);

  logic [31:0] hx0, hx1, hy0, hy1, ha0, ha1, qx, qy, kap;
  logic [15:0] hh0, hh1, hq;
  logic [32:0] len;
  logic [32:0] arc_sum;
  logic [31:0] arc;
  logic        gdone;

  phac_geo u_geo (
    .clk(clk), .rst(rst), .start(cmd.geo_start),
    .dx(33'(signed'(qx)) - 33'(signed'(hx1))),
    .dy(33'(signed'(qy)) - 33'(signed'(hy1))),
    .done(gdone), .len(len), .hdg(hq)
  );

  assign arc_sum = 33'(ha1) + len;

  phac_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dth(hq - hh0), .ds(arc - ha0), .done(sts.div_done), .kap(kap)
  );

  always_ff @(posedge clk) begin
    if (gdone) arc <= (arc_sum[32] || len[32]) ? 32'hFFFFFFFF : arc_sum[31:0];
  end
  assign sts.geo_done = gdone;

  always_ff @(posedge clk) begin
    if (rst) begin
      hx1 <= '0; hy1 <= '0; ha1 <= '0; hh1 <= '0;
    end else begin
      if (cmd.load) begin
        qx <= pos_x; qy <= pos_y;
      end
      if (cmd.commit) begin
        if (seen == 2'd0) begin
          hx1 <= qx; hy1 <= qy; ha1 <= '0; hh1 <= '0;
        end else begin
          hx0 <= hx1; hy0 <= hy1; ha0 <= ha1; hh0 <= (seen == 2'd1) ? hq : hh1;
          hx1 <= qx; hy1 <= qy; ha1 <= arc; hh1 <= hq;
        end
      end
    end
  end

  // sel: 0 = prev point, 1 = held point, 2 = new final point, 3 = lone point
  always_comb begin
    res = '0;
    unique case (sel)
      2'd0: res = '{x: hx0, y: hy0, arc: ha0, hdg: hh0, kap: kap, fin: 1'b0};
      2'd1: res = '{x: hx1, y: hy1, arc: ha1, hdg: (seen == 2'd1) ? hq : hh1,
                    kap: (seen == 2'd1) ? 32'h0 : kap, fin: 1'b0};
      2'd2: res = '{x: qx, y: qy, arc: arc, hdg: hq,
                    kap: (seen == 2'd1) ? 32'h0 : kap, fin: 1'b1};
      default: res = '{x: qx, y: qy, arc: 32'h0, hdg: 16'h0, kap: 32'h0, fin: 1'b1};
    endcase
  end

endmodule

// File: rtl/phac_ctrl.sv
// ----------------------------------------------------------------------------
// phac_ctrl
// Controller: sequences geometry, divide and result words per point.
// ----------------------------------------------------------------------------
module phac_ctrl
  import phac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       end_of_path,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic [1:0] sel,
  output logic [1:0] seen,
  output logic       res_load,
  input  logic       res_free
);

  typedef enum logic [2:0] {
    S_IDLE, S_GEO, S_DIV, S_EMIT, S_DONE
  } state_t;

  state_t     state;
  logic       last;
  logic [1:0] cur;
  cmd_t       cmd_q;

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_EMIT) && res_free;

  // load and commit act on the accepting edge and the edge leaving S_DONE
  always_comb begin
    cmd = cmd_q;
    cmd.load = in_valid && (state == S_IDLE);
    cmd.commit = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; seen <= '0; cmd_q <= '0; sel <= '0; last <= 1'b0; cur <= '0;
    end else begin
      cmd_q <= '0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last <= end_of_path;
            if (seen == 2'd0) begin
              if (end_of_path) begin
                sel <= 2'd3; state <= S_EMIT;
              end else begin
                state <= S_DONE;
              end
            end else begin
              state <= S_GEO;
            end
          end
        end
        S_GEO: begin
          if (!cmd_q.geo_start && cur == 2'd0) begin
            cmd_q.geo_start <= 1'b1; cur <= 2'd1;
          end else if (sts.geo_done) begin
            cur <= '0;
            if (seen == 2'd1) begin
              if (last) begin
                sel <= 2'd1; state <= S_EMIT;
              end else begin
                state <= S_DONE;
              end
            end else begin
              cmd_q.div_start <= 1'b1; state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            sel <= (seen == 2'd2) ? 2'd0 : 2'd1; state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_free) begin
            if (sel == 2'd0) sel <= 2'd1;
            else if (sel == 2'd1 && last) sel <= 2'd2;
            else if (sel == 2'd3 || sel == 2'd2) begin
              seen <= '0; state <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        default: begin
          seen <= (seen == 2'd0) ? 2'd1 : ((seen == 2'd1) ? 2'd2 : 2'd3);
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/phac_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phac_checker
// Watches both channels of the path block, predicts every result word from
// the accepted points and compares the words that leave the block in order.
// ----------------------------------------------------------------------------
module phac_checker
  import phac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic        end_of_path,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_x,
  input  logic [31:0] out_y,
  input  logic [31:0] arc_length,
  input  logic [15:0] heading,
  input  logic [31:0] curvature,
  input  logic        final_point,
  output int          fails,
  output int          pending
);

  word_t       exp_words[$];
  logic [1:0]  seen;
  logic [31:0] hx[2], hy[2], harc[2], pkap;
  logic [15:0] hhd[2];

  function automatic logic [32:0] seg_len(longint dx, longint dy);
    logic [65:0] s;
    logic [67:0] root, rem, trial;
    logic [63:0] ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    s = {2'b0, ax} * {2'b0, ax} + {2'b0, ay} * {2'b0, ay};
    root = 0;
    rem = 0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | s[2*k +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) root = root + 1;
    return root[32:0];
  endfunction

  function automatic logic [31:0] atan_tab(int i);
    logic [31:0] t[32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h0, 32'h0};
    return t[i];
  endfunction

  function automatic logic [15:0] bearing(longint dx, longint dy);
    logic [31:0] acc;
    longint x, y, xs, ys;
    if (dx == 0 && dy == 0) return 16'd0;
    x = dx;
    y = dy;
    acc = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + atan_tab(i);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - atan_tab(i);
      end
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  function automatic logic [31:0] bend(logic [15:0] hn, logic [15:0] hp, logic [31:0] ds);
    logic [15:0] d16;
    longint dt, num, den, q;
    d16 = hn - hp;
    dt = longint'($signed(d16));
    if (dt == 0) return 32'd0;
    if (ds == 0) return dt > 0 ? 32'h7FFFFFFF : 32'h80000000;
    num = dt * 64'd411774832;
    if (num < 0) num = -num;
    den = longint'(ds) * 65536;
    q = (num + den / 2) / den;
    if (dt > 0) return q > 64'h7FFFFFFF ? 32'h7FFFFFFF : q[31:0];
    if (q > 64'h80000000) q = 64'h80000000;
    return 32'd0 - q[31:0];
  endfunction

  function automatic word_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] a,
                               logic [15:0] h, logic [31:0] k, logic f);
    word_t w;
    w.x = x; w.y = y; w.arc = a; w.hdg = h; w.kap = k; w.fin = f;
    return w;
  endfunction

  task automatic enqueue(word_t w);
    exp_words = {exp_words, w};
  endtask

  task automatic clear_path();
    seen = 0;
    hx = '{0, 0}; hy = '{0, 0}; harc = '{0, 0}; hhd = '{0, 0};
    pkap = 0;
  endtask

  task automatic predict_point(logic [31:0] qx, logic [31:0] qy, logic e);
    longint dx, dy, a64;
    logic [15:0] hq;
    logic [31:0] arc, kap;
    if (seen == 0) begin
      if (e) begin
        enqueue(mk(qx, qy, '0, '0, '0, 1'b1));
        clear_path();
        return;
      end
      hx[1] = qx; hy[1] = qy; harc[1] = 0; hhd[1] = 0;
      seen = 1;
      return;
    end
    dx = longint'($signed(qx)) - longint'($signed(hx[1]));
    dy = longint'($signed(qy)) - longint'($signed(hy[1]));
    hq = bearing(dx, dy);
    a64 = longint'(harc[1]) + longint'(seg_len(dx, dy));
    arc = a64 > 64'hFFFFFFFF ? 32'hFFFFFFFF : a64[31:0];
    if (seen == 1) begin
      if (e) begin
        enqueue(mk(hx[1], hy[1], harc[1], hq, '0, 1'b0));
        enqueue(mk(qx, qy, arc, hq, '0, 1'b1));
        clear_path();
        return;
      end
      hhd[1] = hq;
    end else begin
      kap = bend(hq, hhd[0], arc - harc[0]);
      pkap = kap;
      if (seen == 2) enqueue(mk(hx[0], hy[0], harc[0], hhd[0], kap, 1'b0));
      enqueue(mk(hx[1], hy[1], harc[1], hhd[1], kap, 1'b0));
      if (e) begin
        enqueue(mk(qx, qy, arc, hq, pkap, 1'b1));
        clear_path();
        return;
      end
    end
    hx[0] = hx[1]; hy[0] = hy[1]; harc[0] = harc[1]; hhd[0] = hhd[1];
    hx[1] = qx; hy[1] = qy; harc[1] = arc; hhd[1] = hq;
    seen = (seen == 1) ? 2 : 3;
  endtask

  task automatic cmp(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      fails++;
      $display("%0t mismatch %s: expected %h actual %h", $realtime, nm, e, a);
    end
  endtask

  assign pending = exp_words.size();

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      clear_path();
      exp_words.delete();
    end else begin
      if (in_valid && in_ready) predict_point(pos_x, pos_y, end_of_path);
      if (out_valid && out_ready) begin
        if (exp_words.size() == 0) begin
          fails++;
          $display("%0t unexpected word: actual x %h y %h", $realtime, out_x, out_y);
        end else begin
          w = exp_words.pop_front();
          cmp("out_x", w.x, out_x);
          cmp("out_y", w.y, out_y);
          cmp("arc_length", w.arc, arc_length);
          cmp("heading", {16'd0, w.hdg}, {16'd0, heading});
          cmp("curvature", w.kap, curvature);
          cmp("final_point", {31'd0, w.fin}, {31'd0, final_point});
        end
      end
    end
  end

endmodule

// File: tb/tb_path_heading_arc_curvature.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_path_heading_arc_curvature
// Feeds paths of points to the block: directed corner paths (single and
// double points, zero segments, saturating arcs), then random paths, with
// random gaps on both sides, a long sink stall and a drained pause.
// ----------------------------------------------------------------------------
module tb_path_heading_arc_curvature;
  import phac_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] pos_x = 0;
  logic [31:0] pos_y = 0;
  logic        end_of_path = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_x, out_y, arc_length, curvature;
  logic [15:0] heading;
  logic        final_point;
  int          fails, pending;
  int          idle_cnt = 0;

  localparam int IdleLimit = 4000;
  localparam logic [31:0] MinV = 32'h80000000;
  localparam logic [31:0] MaxV = 32'h7FFFFFFF;

  always #1 clk = ~clk;

  path_heading_arc_curvature dut (.*);

  phac_checker chk (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sink
  initial begin
    int w;
    int taken;
    logic held;
    taken = 0;
    held = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!held && taken == 120) begin
        held = 1;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      w = $urandom_range(0, 5);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic e, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    pos_x <= x;
    pos_y <= y;
    end_of_path <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic rand_path(int n, logic wide, int max_gap);
    logic [31:0] x, y;
    x = $urandom;
    y = $urandom;
    for (int i = 0; i < n; i++) begin
      if (wide || $urandom_range(0, 9) == 0) begin
        x = $urandom;
        y = $urandom;
      end else if ($urandom_range(0, 7) != 0) begin
        x = x + $urandom_range(0, 4000) - 2000;
        y = y + $urandom_range(0, 4000) - 2000;
      end
      send_point(x, y, i == n - 1, $urandom_range(0, max_gap));
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 0;
    // single points at the extremes
    send_point(MinV, MaxV, 1, 0);
    send_point(MaxV, MinV, 1, 1);
    // two-point path
    send_point(0, 0, 0, 0);
    send_point(1000, -1000, 1, 2);
    // zero-length segment in the middle
    send_point(10, 10, 0, 0);
    send_point(10, 10, 0, 0);
    send_point(500, 20, 0, 3);
    send_point(500, 900, 1, 0);
    // saturating arc, zero ds with changing heading
    send_point(MinV, MinV, 0, 0);
    send_point(MaxV, MaxV, 0, 0);
    send_point(MinV, MaxV, 0, 0);
    send_point(MaxV, MinV, 0, 0);
    send_point(MaxV, MaxV, 1, 0);
    // tight turn, large curvature
    send_point(0, 0, 0, 0);
    send_point(1, 0, 0, 0);
    send_point(1, 1, 0, 0);
    send_point(0, 1, 0, 0);
    send_point(-1, -1, 1, 0);
    drain();
    n = 0;
    while (n < 310) begin
      int len;
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = 2;
        default: len = $urandom_range(3, 10);
      endcase
      if (n >= 150 && n < 160) begin
        rand_path(len, 0, 0);
        drain();
      end else begin
        rand_path(len, $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0 ? 0 : 5);
      end
      n = n + len;
    end
    drain();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
